// ===== src/seeded_variable_step_lowpass_macros.svh =====
// assertion macros shared by the filter block
// no dependencies; included by files that carry concurrent assertions
`ifndef SEEDED_VARIABLE_STEP_LOWPASS_MACROS_SVH
`define SEEDED_VARIABLE_STEP_LOWPASS_MACROS_SVH

// same-cycle implication, checked outside reset
`define SVLP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SVLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/svlp_pkg.sv =====
// shared types and constants for the seeded variable-step low-pass block
// no dependencies; imported by svlp_div and seeded_variable_step_lowpass
package svlp_pkg;

    // field widths
    localparam int TEMP_W  = 16;
    localparam int TIME_W  = 32;
    localparam int MS_W    = 16;
    localparam int COUNT_W = 8;
    localparam int FAULT_W = 3;
    localparam int DEN_W   = MS_W + 1;

    // stream beat widths
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 112;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_SEED_MIN    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SEED_MAX    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_SAMPLES = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_TAU         = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAP_LIMIT   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_PUB_IVL     = 3'd5;

    // register reset values
    localparam logic [TEMP_W-1:0]  RST_SEED_MIN    = 16'sd0;
    localparam logic [TEMP_W-1:0]  RST_SEED_MAX    = 16'sd3200;
    localparam logic [COUNT_W-1:0] RST_MIN_SAMPLES = 8'd3;
    localparam logic [MS_W-1:0]    RST_TAU         = 16'd2000;
    localparam logic [MS_W-1:0]    RST_GAP_LIMIT   = 16'd5000;
    localparam logic [MS_W-1:0]    RST_PUB_IVL     = 16'd250;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_LOAD,
        ST_DIV,
        ST_FIN
    } t_state;

    // kind of filter update chosen for one read
    typedef enum logic [1:0] {
        UPD_HOLD,
        UPD_LOAD,
        UPD_STEP
    } t_upd;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // sequencer controls
    typedef struct packed {
        logic ready;
        logic div_start;
        logic commit;
    } t_seq_ctl;

endpackage

// ===== src/svlp_div.sv =====
// restoring divider, one quotient bit per cycle, for the filter step
// depends on svlp_pkg; caller guarantees the numerator's high part is below the divisor
module svlp_div
    import svlp_pkg::*;
#(
    parameter int HI_W  = 16,
    parameter int QUO_W = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [HI_W+QUO_W-1:0]   i_num,
    input  logic [DEN_W-1:0]        i_den,
    output logic [QUO_W-1:0]        o_quo,
    output t_div_stat               o_stat
);

    localparam int NUM_W = HI_W + QUO_W;
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DEN_W-1:0] r_rem;
    logic [QUO_W-1:0] r_low;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   w_trial;
    logic [DEN_W+1:0] w_sub;
    logic             w_fit;

    // trial subtract of the divisor from the shifted remainder
    assign w_trial = {r_rem, r_low[QUO_W-1]};
    assign w_sub   = {1'b0, w_trial} - {2'b00, r_den};
    assign w_fit   = ~w_sub[DEN_W+1];

    // control: busy flag, step count, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - {{(CNT_W-1){1'b0}}, 1'b1};
                if (r_cnt == {{(CNT_W-1){1'b0}}, 1'b1}) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: remainder and the low word that trades numerator bits for quotient bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {{(DEN_W-HI_W){1'b0}}, i_num[NUM_W-1:QUO_W]};
            r_low <= i_num[QUO_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_sub[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_low <= {r_low[QUO_W-2:0], w_fit};
        end
    end

    assign o_quo       = r_low;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ===== src/seeded_variable_step_lowpass.sv =====
// top level of the seeded variable-step low-pass filter with telemetry record
// depends on svlp_pkg, svlp_div and seeded_variable_step_lowpass_macros.svh
//
//  channel  | direction | beat contents
//  ---------+-----------+----------------------------------------------------
//  s        | in        | one converter read (fault, temps, count, timestamp)
//  m        | out       | one record view per read, with published flag
//  cfg      | in        | register write: i_cfg_we, i_cfg_addr, i_cfg_wdata
//
// a read that steps the filter goes through the decision, load, divide and finish states,
// the serial divider producing one quotient bit per cycle; a fault read or one that
// only seeds, reloads or holds goes from the decision state straight to finish.
// synchronous active-low reset restores the register defaults and clears the state.
// o_s_tready is high only when idle; a held output beat stalls only the final commit.
`include "seeded_variable_step_lowpass_macros.svh"

module seeded_variable_step_lowpass
    import svlp_pkg::*;
#(
    parameter int FILTER_FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // fault[2:0], probe_temp[18:3], internal_temp[34:19], median_temp[50:35],
    // sample_count[58:51], timestamp_ms[90:59], zero fill above
    input  logic [IN_TDATA_W-1:0]   i_s_tdata,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    // published[0], rec_timestamp[32:1], rec_probe[48:33], rec_internal[64:49],
    // rec_median[80:65], rec_filtered[96:81], rec_filter_seeded[97],
    // rec_count[105:98], rec_valid[106], rec_fault[109:107], zero fill above
    output logic [OUT_TDATA_W-1:0]  o_m_tdata,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    input  logic                    i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata
);

    localparam int FW = TEMP_W + FILTER_FRAC_BITS;
    localparam int NW = MS_W + FW;

    // configuration registers
    logic signed [TEMP_W-1:0] r_cfg_seed_min;
    logic signed [TEMP_W-1:0] r_cfg_seed_max;
    logic [COUNT_W-1:0]       r_cfg_min_samples;
    logic [MS_W-1:0]          r_cfg_tau;
    logic [MS_W-1:0]          r_cfg_gap;
    logic [MS_W-1:0]          r_cfg_pub_ivl;

    // sequencer
    t_state   r_state, n_state;
    t_seq_ctl w_ctl;

    // captured read
    logic [FAULT_W-1:0]       r_fault;
    logic [TEMP_W-1:0]        r_probe_in;
    logic [TEMP_W-1:0]        r_internal_in;
    logic signed [TEMP_W-1:0] r_median;
    logic [COUNT_W-1:0]       r_count;
    logic [TIME_W-1:0]        r_ts;

    // filter state
    logic signed [FW-1:0] r_filter, n_filter;
    logic                 r_seeded, n_seeded;
    logic [TIME_W-1:0]    r_last_filt_time;
    logic [TIME_W-1:0]    r_last_pub_time;
    logic [TEMP_W-1:0]    r_last_probe;
    logic [TEMP_W-1:0]    r_last_internal;

    // telemetry record
    logic [TIME_W-1:0]  r_rec_ts, n_rec_ts;
    logic [TEMP_W-1:0]  r_rec_probe, n_rec_probe;
    logic [TEMP_W-1:0]  r_rec_internal, n_rec_internal;
    logic [TEMP_W-1:0]  r_rec_median, n_rec_median;
    logic [TEMP_W-1:0]  r_rec_filtered, n_rec_filtered;
    logic               r_rec_seeded, n_rec_seeded;
    logic [COUNT_W-1:0] r_rec_count, n_rec_count;
    logic               r_rec_valid, n_rec_valid;
    logic [FAULT_W-1:0] r_rec_fault, n_rec_fault;

    // step decision and divider operands
    t_upd             r_upd, w_upd;
    logic             r_set_time, w_set_time;
    logic             r_neg;
    logic [NW-1:0]    r_prod;
    logic [DEN_W-1:0] r_den;

    // output register
    logic                   r_m_tvalid;
    logic [OUT_TDATA_W-1:0] r_m_tdata;

    // decision-cycle datapath
    logic signed [FW-1:0] w_m;
    logic [TIME_W-1:0]    w_dt;
    logic                 w_gap;
    logic                 w_seed_ok;
    logic signed [FW:0]   w_diff;
    logic [FW:0]          w_mag_full;
    logic [FW-1:0]        w_mag;
    logic [NW-1:0]        w_prod;
    logic [DEN_W-1:0]     w_den;

    // commit-cycle datapath
    logic [FW-1:0]        w_quo;
    t_div_stat            w_div_stat;
    logic signed [FW:0]   w_qs;
    logic signed [FW:0]   w_step;
    logic [TIME_W-1:0]    w_pub_age;
    logic                 w_pub;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_seed_min    <= RST_SEED_MIN;
            r_cfg_seed_max    <= RST_SEED_MAX;
            r_cfg_min_samples <= RST_MIN_SAMPLES;
            r_cfg_tau         <= RST_TAU;
            r_cfg_gap         <= RST_GAP_LIMIT;
            r_cfg_pub_ivl     <= RST_PUB_IVL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SEED_MIN:    r_cfg_seed_min    <= i_cfg_wdata;
                CFG_SEED_MAX:    r_cfg_seed_max    <= i_cfg_wdata;
                CFG_MIN_SAMPLES: r_cfg_min_samples <= i_cfg_wdata[COUNT_W-1:0];
                CFG_TAU:         r_cfg_tau         <= i_cfg_wdata;
                CFG_GAP_LIMIT:   r_cfg_gap         <= i_cfg_wdata;
                CFG_PUB_IVL:     r_cfg_pub_ivl     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer outputs
    always_comb begin
        w_ctl.ready     = (r_state == ST_IDLE);
        w_ctl.div_start = (r_state == ST_LOAD);
        w_ctl.commit    = (r_state == ST_FIN) && (!r_m_tvalid || i_m_tready);
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_s_tvalid) begin
                n_state = ST_CALC;
            end
            ST_CALC: n_state = (w_upd == UPD_STEP) ? ST_LOAD : ST_FIN;
            ST_LOAD: n_state = ST_DIV;
            ST_DIV:  if (w_div_stat.done) begin
                n_state = ST_FIN;
            end
            ST_FIN:  if (w_ctl.commit) begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (w_ctl.ready && i_s_tvalid) begin
            r_fault       <= i_s_tdata[2:0];
            r_probe_in    <= i_s_tdata[18:3];
            r_internal_in <= i_s_tdata[34:19];
            r_median      <= i_s_tdata[50:35];
            r_count       <= i_s_tdata[58:51];
            r_ts          <= i_s_tdata[90:59];
        end
    end

    // elapsed time, seed check and the step's product and divisor
    assign w_m        = {r_median, {FILTER_FRAC_BITS{1'b0}}};
    assign w_dt       = r_ts - r_last_filt_time;
    assign w_gap      = w_dt > {{(TIME_W-MS_W){1'b0}}, r_cfg_gap};
    assign w_seed_ok  = (r_count >= r_cfg_min_samples) && (r_median >= r_cfg_seed_min)
                        && (r_median <= r_cfg_seed_max);
    assign w_diff     = {w_m[FW-1], w_m} - {r_filter[FW-1], r_filter};
    assign w_mag_full = w_diff[FW] ? -w_diff : w_diff;
    assign w_mag      = w_mag_full[FW-1:0];
    assign w_prod     = {{FW{1'b0}}, w_dt[MS_W-1:0]} * {{MS_W{1'b0}}, w_mag};
    assign w_den      = {1'b0, r_cfg_tau} + {1'b0, w_dt[MS_W-1:0]};

    // update kind for this read
    always_comb begin
        w_upd      = UPD_HOLD;
        w_set_time = 1'b0;
        priority if (r_fault != '0) begin
            w_upd      = UPD_HOLD;
        end else if (!r_seeded) begin
            if (w_seed_ok) begin
                w_upd      = UPD_LOAD;
                w_set_time = 1'b1;
            end
        end else begin
            w_set_time = 1'b1;
            if (w_gap) begin
                w_upd = UPD_LOAD;
            end else if (w_dt != '0) begin
                w_upd = UPD_STEP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CALC) begin
            r_upd      <= w_upd;
            r_set_time <= w_set_time;
            r_neg      <= w_diff[FW];
            r_prod     <= w_prod;
            r_den      <= w_den;
        end
    end

    // divider for dt*(m - filter)/(tau + dt)
    svlp_div #(
        .HI_W  (MS_W),
        .QUO_W (FW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctl.div_start),
        .i_num   (r_prod),
        .i_den   (r_den),
        .o_quo   (w_quo),
        .o_stat  (w_div_stat)
    );

    // new filter value, truncated quotient carries the sign of the difference
    assign w_qs   = r_neg ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});
    assign w_step = {r_filter[FW-1], r_filter} + w_qs;

    always_comb begin
        unique case (r_upd)
            UPD_LOAD: n_filter = w_m;
            UPD_STEP: n_filter = w_step[FW-1:0];
            default:  n_filter = r_filter;
        endcase
        n_seeded = r_seeded || (r_upd == UPD_LOAD);
    end

    // publish check and next record
    assign w_pub_age = r_ts - r_last_pub_time;
    assign w_pub     = (r_fault == '0) &&
                       (w_pub_age >= {{(TIME_W-MS_W){1'b0}}, r_cfg_pub_ivl});

    always_comb begin
        n_rec_ts       = r_rec_ts;
        n_rec_probe    = r_rec_probe;
        n_rec_internal = r_rec_internal;
        n_rec_median   = r_rec_median;
        n_rec_filtered = r_rec_filtered;
        n_rec_seeded   = r_rec_seeded;
        n_rec_count    = r_rec_count;
        n_rec_valid    = r_rec_valid;
        n_rec_fault    = r_rec_fault;
        priority if (r_fault != '0) begin
            n_rec_fault = r_fault;
            n_rec_valid = 1'b0;
        end else if (w_pub) begin
            n_rec_ts       = r_ts;
            n_rec_probe    = r_probe_in;
            n_rec_internal = r_internal_in;
            n_rec_median   = r_median;
            n_rec_filtered = n_seeded ? n_filter[FW-1:FILTER_FRAC_BITS] : '0;
            n_rec_seeded   = n_seeded;
            n_rec_count    = r_count;
            n_rec_valid    = 1'b1;
            n_rec_fault    = '0;
        end
    end

    // state commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter         <= '0;
            r_seeded         <= 1'b0;
            r_last_filt_time <= '0;
            r_last_pub_time  <= '0;
            r_last_probe     <= '0;
            r_last_internal  <= '0;
            r_rec_ts         <= '0;
            r_rec_probe      <= '0;
            r_rec_internal   <= '0;
            r_rec_median     <= '0;
            r_rec_filtered   <= '0;
            r_rec_seeded     <= 1'b0;
            r_rec_count      <= '0;
            r_rec_valid      <= 1'b0;
            r_rec_fault      <= '0;
        end else if (w_ctl.commit) begin
            r_filter <= n_filter;
            r_seeded <= n_seeded;
            if (r_set_time) begin
                r_last_filt_time <= r_ts;
            end
            if (w_pub) begin
                r_last_pub_time <= r_ts;
            end
            if (r_fault == '0) begin
                r_last_probe    <= r_probe_in;
                r_last_internal <= r_internal_in;
            end
            r_rec_ts       <= n_rec_ts;
            r_rec_probe    <= n_rec_probe;
            r_rec_internal <= n_rec_internal;
            r_rec_median   <= n_rec_median;
            r_rec_filtered <= n_rec_filtered;
            r_rec_seeded   <= n_rec_seeded;
            r_rec_count    <= n_rec_count;
            r_rec_valid    <= n_rec_valid;
            r_rec_fault    <= n_rec_fault;
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_ctl.commit) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.commit) begin
            r_m_tdata <= {2'b00, n_rec_fault, n_rec_valid, n_rec_count, n_rec_seeded,
                          n_rec_filtered, n_rec_median, n_rec_internal, n_rec_probe,
                          n_rec_ts, w_pub};
        end
    end

    assign o_s_tready = w_ctl.ready;
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    // checks on the sequencer and the divider handoff
    `SVLP_ASSERT_NEXT(a_accept_to_calc, i_clk, i_rst_n, i_s_tvalid && o_s_tready,
        r_state == ST_CALC, "accepted beat did not start the decision cycle")
    `SVLP_ASSERT_NOW(a_div_done_in_wait, i_clk, i_rst_n, w_div_stat.done,
        r_state == ST_DIV, "divider finished outside the wait state")
    `SVLP_ASSERT_NOW(a_out_from_commit, i_clk, i_rst_n, $rose(o_m_tvalid),
        $past(r_state) == ST_FIN, "output beat raised without a commit")
    `SVLP_ASSERT_NOW(a_seed_sticks, i_clk, i_rst_n, 1'b1,
        !$fell(r_seeded), "filter lost its seeded flag")

endmodule

// ===== verif/lowpass_record_checker.sv =====
// checker for the seeded variable-step low-pass filter: watches the read, record and
// register channels, predicts every record beat and compares it field by field
// depends on svlp_pkg
`timescale 1ns / 100ps

module lowpass_record_checker
    import svlp_pkg::*;
#(
    parameter int FRAC = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    output int                     o_mismatches,
    output int                     o_outstanding
);

    // one record view as it leaves the block
    typedef struct {
        logic                published;
        logic [TIME_W-1:0]   stamp;
        logic [TEMP_W-1:0]   probe;
        logic [TEMP_W-1:0]   internal;
        logic [TEMP_W-1:0]   median;
        logic [TEMP_W-1:0]   filtered;
        logic                seeded;
        logic [COUNT_W-1:0]  count;
        logic                valid;
        logic [FAULT_W-1:0]  fault;
    } t_record;

    // register copies
    logic signed [TEMP_W-1:0] seed_lo;
    logic signed [TEMP_W-1:0] seed_hi;
    logic [COUNT_W-1:0]       need_samples;
    logic [MS_W-1:0]          tau_ms;
    logic [MS_W-1:0]          gap_ms;
    logic [MS_W-1:0]          pub_ms;

    // filter and telemetry state
    longint                   filt;
    logic                     filt_seeded;
    logic [TIME_W-1:0]        filt_stamp;
    logic [TIME_W-1:0]        pub_stamp;
    logic [TEMP_W-1:0]        held_probe;
    logic [TEMP_W-1:0]        held_internal;
    t_record                  shown;

    t_record                  record_due [$];
    int                       mismatch_count = 0;

    // run one read through the filter and return the record view it yields
    task automatic apply_read(input logic [IN_TDATA_W-1:0] beat, output t_record res);
        logic [FAULT_W-1:0]       fault;
        logic signed [TEMP_W-1:0] med;
        logic [COUNT_W-1:0]       cnt;
        logic [TIME_W-1:0]        stamp;
        logic [TIME_W-1:0]        dt;
        logic [TIME_W-1:0]        since;
        longint                   target;
        longint                   whole;
        logic                     pub;
        fault  = beat[2:0];
        med    = beat[50:35];
        cnt    = beat[58:51];
        stamp  = beat[90:59];
        target = longint'(med) * (longint'(1) << FRAC);
        pub    = 1'b0;
        if (fault != '0) begin
            // fault read only marks the record
            shown.fault = fault;
            shown.valid = 1'b0;
        end else begin
            held_probe    = beat[18:3];
            held_internal = beat[34:19];
            if (!filt_seeded) begin
                if (cnt >= need_samples && med >= seed_lo && med <= seed_hi) begin
                    filt        = target;
                    filt_seeded = 1'b1;
                    filt_stamp  = stamp;
                end
            end else begin
                // reload on a long gap, otherwise a step scaled by dt/(tau+dt)
                dt = stamp - filt_stamp;
                if (dt > TIME_W'(gap_ms)) begin
                    filt = target;
                end else if (dt != '0) begin
                    filt = filt + (longint'(dt) * (target - filt)) /
                                  (longint'(tau_ms) + longint'(dt));
                end
                filt_stamp = stamp;
            end
            // refresh the record once the publish interval has passed
            since = stamp - pub_stamp;
            if (since >= TIME_W'(pub_ms)) begin
                whole           = filt_seeded ? (filt >>> FRAC) : 64'sd0;
                pub_stamp       = stamp;
                pub             = 1'b1;
                shown.stamp     = stamp;
                shown.probe     = held_probe;
                shown.internal  = held_internal;
                shown.median    = med;
                shown.filtered  = whole[TEMP_W-1:0];
                shown.seeded    = filt_seeded;
                shown.count     = cnt;
                shown.valid     = 1'b1;
                shown.fault     = '0;
            end
        end
        res           = shown;
        res.published = pub;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // register writes, read beats and record beats in acceptance order
    always @(posedge i_clk) begin
        t_record fresh;
        t_record want;
        if (!i_rst_n) begin
            seed_lo       = RST_SEED_MIN;
            seed_hi       = RST_SEED_MAX;
            need_samples  = RST_MIN_SAMPLES;
            tau_ms        = RST_TAU;
            gap_ms        = RST_GAP_LIMIT;
            pub_ms        = RST_PUB_IVL;
            filt          = 0;
            filt_seeded   = 1'b0;
            filt_stamp    = '0;
            pub_stamp     = '0;
            held_probe    = '0;
            held_internal = '0;
            shown         = '{default: '0};
            record_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SEED_MIN:    seed_lo      = i_cfg_wdata;
                    CFG_SEED_MAX:    seed_hi      = i_cfg_wdata;
                    CFG_MIN_SAMPLES: need_samples = i_cfg_wdata[COUNT_W-1:0];
                    CFG_TAU:         tau_ms       = i_cfg_wdata;
                    CFG_GAP_LIMIT:   gap_ms       = i_cfg_wdata;
                    CFG_PUB_IVL:     pub_ms       = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_read(i_s_tdata, fresh);
                record_due.push_back(fresh);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (record_due.size() == 0) begin
                    $error("record beat with nothing expected: 0x%0h", i_m_tdata);
                    mismatch_count++;
                end else begin
                    want = record_due.pop_front();
                    check_field("published", want.published, i_m_tdata[0]);
                    check_field("rec_timestamp", want.stamp, i_m_tdata[32:1]);
                    check_field("rec_probe", want.probe, i_m_tdata[48:33]);
                    check_field("rec_internal", want.internal, i_m_tdata[64:49]);
                    check_field("rec_median", want.median, i_m_tdata[80:65]);
                    check_field("rec_filtered", want.filtered, i_m_tdata[96:81]);
                    check_field("rec_filter_seeded", want.seeded, i_m_tdata[97]);
                    check_field("rec_count", want.count, i_m_tdata[105:98]);
                    check_field("rec_valid", want.valid, i_m_tdata[106]);
                    check_field("rec_fault", want.fault, i_m_tdata[109:107]);
                end
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= record_due.size();
    end

endmodule

// ===== verif/testbench.sv =====
// top of the low-pass filter testbench: clock, reset, read and register stimulus,
// receiver back-pressure and the verdict
// depends on svlp_pkg, seeded_variable_step_lowpass and lowpass_record_checker
`timescale 1ns / 100ps

module testbench;
    import svlp_pkg::*;

    localparam int FRAC         = 16;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_READS  = 322;
    localparam int DRAIN_CYCLES = 40;

    // one full set of register values
    typedef struct {
        logic [TEMP_W-1:0]  seed_lo;
        logic [TEMP_W-1:0]  seed_hi;
        logic [COUNT_W-1:0] need;
        logic [MS_W-1:0]    tau;
        logic [MS_W-1:0]    gap;
        logic [MS_W-1:0]    pub;
    } t_settings;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = CFG_SEED_MIN;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int          mismatches;
    int          outstanding;
    int          stall_cycles  = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_token    = 0;
    int          hold_seen     = 0;
    int          hold_left     = 0;
    t_settings   cur;
    logic [31:0] ts_now = '0;
    int          prev_med = 0;

    always #10 clk = ~clk;

    seeded_variable_step_lowpass #(
        .FILTER_FRAC_BITS(FRAC)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tdata   (s_tdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    lowpass_record_checker #(
        .FRAC(FRAC)
    ) record_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tdata     (s_tdata),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wdata   (cfg_wdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk) begin
        if (hold_seen != hold_token) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any accepted beat or register write
    always @(posedge clk) begin
        if (!rst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // fault[2:0], probe[18:3], internal[34:19], median[50:35], count[58:51], stamp[90:59]
    function automatic logic [IN_TDATA_W-1:0] pack_read(
        input logic [FAULT_W-1:0] fault, input logic [TEMP_W-1:0] probe,
        input logic [TEMP_W-1:0] internal, input logic [TEMP_W-1:0] median,
        input logic [COUNT_W-1:0] count, input logic [TIME_W-1:0] stamp);
        return {5'b0, stamp, count, median, internal, probe, fault};
    endfunction

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // offer one read beat after a random idle gap and wait for its acceptance
    task automatic send_read(input logic [IN_TDATA_W-1:0] beat);
        int idle;
        idle = 0;
        while ($urandom_range(0, 99) < send_idle_pct) idle++;
        if (idle != 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        s_tdata  <= beat;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic good_read(input int median, input int count, input logic [31:0] stamp);
        send_read(pack_read('0, $urandom, $urandom, median[15:0], count[7:0], stamp));
    endtask

    // stop offering reads and wait until every record beat has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0 || !s_tready);
    endtask

    // write all six registers on consecutive edges
    task automatic load_settings(input t_settings c);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_SEED_MIN;
        cfg_wdata <= c.seed_lo;
        @(posedge clk);
        cfg_addr  <= CFG_SEED_MAX;
        cfg_wdata <= c.seed_hi;
        @(posedge clk);
        cfg_addr  <= CFG_MIN_SAMPLES;
        cfg_wdata <= {8'b0, c.need};
        @(posedge clk);
        cfg_addr  <= CFG_TAU;
        cfg_wdata <= c.tau;
        @(posedge clk);
        cfg_addr  <= CFG_GAP_LIMIT;
        cfg_wdata <= c.gap;
        @(posedge clk);
        cfg_addr  <= CFG_PUB_IVL;
        cfg_wdata <= c.pub;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly a steady stream of good reads, some faults and some noise
    task automatic make_read(output logic [IN_TDATA_W-1:0] beat);
        int          kind;
        int          pick;
        int          lo;
        int          hi;
        int          med;
        int          gap_span;
        logic [31:0] advance;
        logic [7:0]  cnt;
        kind     = $urandom_range(0, 99);
        lo       = $signed(cur.seed_lo);
        hi       = $signed(cur.seed_hi);
        gap_span = cur.gap;
        if (lo > hi) begin
            lo = -32768;
            hi = 32767;
        end
        if (kind < 7) begin
            beat = pack_read($urandom_range(1, 7), $urandom, $urandom, $urandom,
                             $urandom, $urandom);
        end else if (kind < 12) begin
            ts_now = $urandom;
            beat   = pack_read('0, $urandom, $urandom, $urandom, $urandom, ts_now);
        end else begin
            // spacing: repeats, short steps, steps near the gap limit, long jumps
            pick = $urandom_range(0, 99);
            if (pick < 5)       advance = '0;
            else if (pick < 65) advance = $urandom_range(1, 60);
            else if (pick < 88) advance = $urandom_range(1, gap_span + gap_span / 4 + 1);
            else if (pick < 96) advance = $urandom_range(1, 300000);
            else                advance = gap_span + $urandom_range(0, 1);
            ts_now = ts_now + advance;
            if ($urandom_range(0, 99) < 70) begin
                med = clamp(prev_med + int'($urandom_range(0, 128)) - 64, lo, hi);
            end else begin
                med = lo + int'($urandom_range(0, hi - lo));
            end
            prev_med = med;
            if ($urandom_range(0, 99) < 85) cnt = $urandom_range(cur.need, 255);
            else                            cnt = $urandom;
            beat = pack_read('0, $urandom, $urandom, med[15:0], cnt, ts_now);
        end
    endtask

    initial begin
        logic [IN_TDATA_W-1:0] beat;
        int                    mode;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 33;
        recv_idle_pct <= 74;

        // inverted seed range, zero tau, gap and interval: never seeds, publishes every good read
        cur = '{16'h7fff, 16'h8000, 8'd0, 16'd0, 16'd0, 16'd0};
        load_settings(cur);
        send_read(pack_read(3'd1, $urandom, $urandom, 16'd100, 8'd10, 32'd0));
        good_read(0, 0, 32'd0);
        send_read(pack_read('0, 16'h8000, 16'h7fff, 16'h7fff, 8'hff, 32'd5));
        send_read(pack_read('0, 16'h7fff, 16'h8000, 16'h8000, 8'h00, 32'hffff_ffff));
        send_read(pack_read(3'd7, 16'hffff, 16'hffff, 16'hffff, 8'hff, 32'hffff_ffff));
        send_read(pack_read(3'd2, $urandom, $urandom, $urandom, $urandom, 32'd3));
        send_read(pack_read(3'd4, $urandom, $urandom, $urandom, $urandom, 32'd4));
        wait_drained();

        // power-on values: seeding rules, hold, step at the gap limit, reload, wrap
        cur = '{16'd0, 16'd3200, 8'd3, 16'd2000, 16'd5000, 16'd250};
        load_settings(cur);
        good_read(100, 2, 32'd1000);
        good_read(-1, 3, 32'd1100);
        good_read(3201, 3, 32'd1250);
        good_read(0, 3, 32'd1300);
        good_read(3200, 200, 32'd1300);
        good_read(3200, 200, 32'd1310);
        good_read(1600, 200, 32'd6310);
        good_read(800, 200, 32'd11311);
        send_read(pack_read(3'd3, $urandom, $urandom, 16'd900, 8'd50, 32'd11400));
        good_read(800, 200, 32'd11400);
        good_read(2000, 200, 32'd11561);
        good_read(1500, 200, 32'hffff_ff00);
        good_read(1500, 200, 32'h0000_0010);
        good_read(-32768, 255, 32'h0000_0020);
        good_read(32767, 255, 32'h0000_0030);
        wait_drained();

        // random phases; idling goes from slow receiver to slow sender to none
        for (int phase = 0; phase < 6; phase++) begin
            mode = phase / 2;
            send_idle_pct = (mode == 0) ? 33 : ((mode == 1) ? 74 : 0);
            recv_idle_pct <= (mode == 0) ? 74 : ((mode == 1) ? 33 : 0);
            case (phase)
                0: cur = '{16'h8000, 16'h7fff, 8'd0, 16'd0, 16'hffff, 16'd0};
                1: cur = '{16'h7fff, 16'h8000, 8'd255, 16'hffff, 16'd0, 16'hffff};
                2: cur = '{-16'sd500, 16'd3200, 8'd3, 16'd1, 16'd5000, 16'd1};
                default: begin
                    cur.seed_lo = 16'(-int'($urandom_range(0, 2000)));
                    cur.seed_hi = $urandom_range(0, 4000);
                    cur.need    = $urandom_range(0, 12);
                    cur.tau     = $urandom_range(1, 5000);
                    cur.gap     = $urandom_range(10, 9000);
                    cur.pub     = $urandom_range(1, 800);
                end
            endcase
            load_settings(cur);
            // long receiver hold-off while reads keep coming
            hold_token <= hold_token + 1;
            if ($urandom_range(0, 2) == 0) ts_now = 32'hffff_ffff - $urandom_range(0, 200000);
            repeat (PHASE_READS) begin
                make_read(beat);
                send_read(beat);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
